/* hdl/bde_pkg.sv */
package bde_pkg;

    localparam int MAX_POINTS = 64;
    localparam int K_W        = 7;
    localparam int COORD_W    = 32;
    localparam int SUM_W      = 40;
    localparam int DIV_CNT_W  = $clog2(SUM_W);

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
    } t_point;

    typedef struct packed {
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic                      end_of_curve;
    } t_result;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_A,
        ST_MUL_B,
        ST_START,
        ST_DIV,
        ST_PUT1,
        ST_PUT2
    } t_state;

endpackage

/* hdl/bde_div.sv */
module bde_div (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [bde_pkg::SUM_W-1:0]     i_dividend,
    input  logic        [bde_pkg::K_W-1:0]       i_divisor,
    output logic                                 o_done,
    output logic signed [bde_pkg::COORD_W-1:0]   o_quotient
);
    import bde_pkg::*;

    logic [SUM_W-1:0]     r_quo;
    logic [K_W-1:0]       r_rem;
    logic [K_W-1:0]       r_den;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_neg;
    logic                 r_done;

    logic [K_W:0]         rem_sh;
    logic [K_W:0]         rem_sub;
    logic                 ge;
    logic [SUM_W-1:0]     mag;
    logic [COORD_W-1:0]   q_mag;

    assign mag     = i_dividend[SUM_W-1] ? (~i_dividend + 1'b1) : i_dividend;
    assign rem_sh  = {r_rem, r_quo[SUM_W-1]};
    assign ge      = (rem_sh >= {1'b0, r_den});
    assign rem_sub = rem_sh - {1'b0, r_den};
    assign q_mag   = r_quo[COORD_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(SUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= mag;
            r_rem <= '0;
            r_den <= i_divisor;
            r_neg <= i_dividend[SUM_W-1];
        end else if (r_busy) begin
            r_quo <= {r_quo[SUM_W-2:0], ge};
            r_rem <= ge ? rem_sub[K_W-1:0] : rem_sh[K_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? $signed(~q_mag + 1'b1) : $signed(q_mag);

endmodule

/* hdl/bezier_degree_elevation.sv */
// Bezier degree elevation: control points enter one transaction at a time and the
// points of the curve raised by one degree leave on the output channel, the last
// one flagged end_of_curve. i_cfg_data sets the point count k (0 acts as 1, above
// 64 acts as 64); write it only while the block is idle. The first point of a
// curve passes straight through; every other point is divided by k in the
// 40-step restoring divider, shared in turn by x and y. The last point of a
// curve is then sent once more as a second result. A new point is taken while
// a result still waits on the output register.
module bezier_degree_elevation (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  bde_pkg::t_point         i_in_data,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output bde_pkg::t_result        o_out_data,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [bde_pkg::K_W-1:0] i_cfg_data
);
    import bde_pkg::*;

    t_state                    r_state, n_state;
    logic [K_W-1:0]            r_point_count;
    logic [K_W-1:0]            r_idx;
    logic signed [COORD_W-1:0] r_prev_x, r_prev_y;
    t_point                    r_cur;
    logic [K_W-1:0]            r_i, r_k;
    logic                      r_last;
    logic                      r_coord;
    logic signed [SUM_W-1:0]   r_acc;
    logic signed [COORD_W-1:0] r_res_x, r_res_y;
    logic                      r_out_valid;
    t_result                   r_out;

    logic                      in_acc;
    logic                      out_free;
    logic                      out_load;
    t_result                   out_next;
    logic [K_W-1:0]            k_eff;
    logic [K_W-1:0]            i_eff;
    logic                      last_eff;
    logic [K_W-1:0]            w_cur;
    logic signed [COORD_W-1:0] op_a, op_b;
    logic signed [SUM_W-1:0]   prod_a, prod_b;
    logic                      div_start;
    logic                      div_done;
    logic signed [COORD_W-1:0] div_q;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        if (r_point_count == '0) begin
            k_eff = K_W'(1);
        end else if (r_point_count > K_W'(MAX_POINTS)) begin
            k_eff = K_W'(MAX_POINTS);
        end else begin
            k_eff = r_point_count;
        end
    end

    assign i_eff    = (r_idx >= k_eff) ? '0 : r_idx;
    assign last_eff = ({1'b0, i_eff} + 1'b1) >= {1'b0, k_eff};

    assign w_cur  = r_k - r_i;
    assign op_a   = r_coord ? r_cur.point_y : r_cur.point_x;
    assign op_b   = r_coord ? r_prev_y : r_prev_x;
    assign prod_a = $signed({1'b0, w_cur}) * SUM_W'(op_a);
    assign prod_b = $signed({1'b0, r_i}) * SUM_W'(op_b);

    bde_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_acc),
        .i_divisor  (r_k),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = (i_eff == '0) ? ST_PUT1 : ST_MUL_A;
                end
            end
            ST_MUL_A: n_state = ST_MUL_B;
            ST_MUL_B: n_state = ST_START;
            ST_START: n_state = ST_DIV;
            ST_DIV: begin
                if (div_done) begin
                    n_state = r_coord ? ST_PUT1 : ST_MUL_A;
                end
            end
            ST_PUT1: begin
                if (out_free) begin
                    n_state = r_last ? ST_PUT2 : ST_IDLE;
                end
            end
            ST_PUT2: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = 1'b1;
        div_start  = 1'b0;
        out_load   = 1'b0;
        out_next   = '{out_x: r_res_x, out_y: r_res_y, end_of_curve: 1'b0};
        case (r_state)
            ST_IDLE:  o_in_stall = 1'b0;
            ST_START: div_start  = 1'b1;
            ST_PUT1:  out_load   = out_free;
            ST_PUT2: begin
                out_load = out_free;
                out_next = '{out_x: r_cur.point_x, out_y: r_cur.point_y,
                             end_of_curve: 1'b1};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_point_count <= K_W'(4);
            r_idx         <= '0;
            r_prev_x      <= '0;
            r_prev_y      <= '0;
            r_coord       <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_point_count <= i_cfg_data;
            end
            if (in_acc) begin
                r_idx   <= last_eff ? '0 : i_eff + 1'b1;
                r_coord <= 1'b0;
            end else if (r_state == ST_DIV && div_done) begin
                r_coord <= 1'b1;
            end
            if (r_state == ST_PUT1 && out_load) begin
                r_prev_x <= r_cur.point_x;
                r_prev_y <= r_cur.point_y;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cur  <= i_in_data;
            r_i    <= i_eff;
            r_k    <= k_eff;
            r_last <= last_eff;
            if (i_eff == '0) begin
                r_res_x <= i_in_data.point_x;
                r_res_y <= i_in_data.point_y;
            end
        end
        if (r_state == ST_MUL_A) begin
            r_acc <= prod_a;
        end else if (r_state == ST_MUL_B) begin
            r_acc <= r_acc + prod_b;
        end
        if (r_state == ST_DIV && div_done) begin
            if (r_coord) begin
                r_res_y <= div_q;
            end else begin
                r_res_x <= div_q;
            end
        end
        if (out_load) begin
            r_out <= out_next;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

/* bench/tb_bezier_degree_elevation.sv */
`timescale 1ns / 1ps

module tb_bezier_degree_elevation;
    import bde_pkg::*;

    localparam int CYCLE_LIMIT   = 2000000;
    localparam int SETTLE_CYCLES = 120;
    localparam int LONG_HOLD     = 600;
    localparam int RANDOM_ITEMS  = 1000;
    localparam int FINAL_ITEMS   = 100;

    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic [K_W-1:0]            COUNT_TOP = {K_W{1'b1}};

    logic             i_clk;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_stall;
    t_point           i_in_data;
    logic             o_out_valid;
    logic             i_out_stall = 1'b0;
    t_result          o_out_data;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [K_W-1:0]   i_cfg_data;

    t_result                   pending_results[$];
    t_result                   head_result;
    logic [K_W-1:0]            count_reg;
    logic signed [COORD_W-1:0] last_x;
    logic signed [COORD_W-1:0] last_y;
    int                        next_index;
    int                        mismatches = 0;
    int                        cycle_count;
    bit                        idle_on = 1'b0;
    int                        holds_asked = 0;
    int                        holds_done = 0;
    int                        stall_left = 0;

    bezier_degree_elevation uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int clamp_count(input logic [K_W-1:0] raw);
        int k;
        k = int'(raw);
        if (k == 0) k = 1;
        if (k > MAX_POINTS) k = MAX_POINTS;
        return k;
    endfunction

    function automatic logic signed [COORD_W-1:0] blend_coord(
        input logic signed [COORD_W-1:0] cur,
        input logic signed [COORD_W-1:0] prev,
        input int i,
        input int k
    );
        longint sum;
        longint quot;
        sum  = longint'(k - i) * longint'(cur) + longint'(i) * longint'(prev);
        quot = sum / longint'(k);
        return quot[COORD_W-1:0];
    endfunction

    function automatic void elevate_point(input t_point p);
        int      k;
        int      i;
        t_result r;
        k = clamp_count(count_reg);
        i = next_index;
        if (i >= k) i = 0;
        if (i == 0) begin
            r.out_x = p.point_x;
            r.out_y = p.point_y;
        end else begin
            r.out_x = blend_coord(p.point_x, last_x, i, k);
            r.out_y = blend_coord(p.point_y, last_y, i, k);
        end
        r.end_of_curve = 1'b0;
        pending_results.push_back(r);
        if (i + 1 >= k) begin
            r.out_x        = p.point_x;
            r.out_y        = p.point_y;
            r.end_of_curve = 1'b1;
            pending_results.push_back(r);
            next_index = 0;
        end else begin
            next_index = i + 1;
        end
        last_x = p.point_x;
        last_y = p.point_y;
    endfunction

    function automatic logic signed [COORD_W-1:0] pick_coord();
        case ($urandom_range(0, 9))
            0: return COORD_MIN;
            1: return COORD_MAX;
            2: return COORD_W'($signed($urandom_range(0, 255)) - 128);
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [K_W-1:0] pick_count();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return '0;
        if (r == 1) return K_W'(MAX_POINTS);
        if (r == 2) return K_W'($urandom_range(MAX_POINTS + 1, int'(COUNT_TOP)));
        if (r < 8) return K_W'($urandom_range(9, 20));
        return K_W'($urandom_range(1, 8));
    endfunction

    // transaction on the point channel; entered and left just after a falling edge
    task automatic send_point(input logic signed [COORD_W-1:0] x,
                              input logic signed [COORD_W-1:0] y);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 10);
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid        = 1'b1;
        i_in_data.point_x = x;
        i_in_data.point_y = y;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        elevate_point(i_in_data);
        @(negedge i_clk);
    endtask

    task automatic send_random(input int n);
        repeat (n) send_point(pick_coord(), pick_coord());
    endtask

    task automatic drain(input int extra);
        i_in_valid = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (extra) @(negedge i_clk);
    endtask

    task automatic write_count(input logic [K_W-1:0] v);
        drain(4);
        i_cfg_valid = 1'b1;
        i_cfg_data  = v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        count_reg = v;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic test_reset_count();
        send_point(COORD_MAX, COORD_MIN);
        send_point(COORD_MIN, COORD_MAX);
        send_point('0, -1);
        send_point(COORD_MAX, COORD_MAX);
    endtask

    task automatic test_extreme_pairs();
        write_count(K_W'(2));
        send_point(COORD_MIN, COORD_MIN);
        send_point(COORD_MAX, COORD_MAX);
        send_point(COORD_MAX, COORD_MIN);
        send_point(COORD_MIN, COORD_MAX);
    endtask

    task automatic test_single_point();
        write_count(K_W'(1));
        send_point(COORD_MIN, COORD_MAX);
        send_point(32'sh0001_8000, -32'sh0000_0001);
        send_point(pick_coord(), pick_coord());
    endtask

    task automatic test_zero_count();
        write_count('0);
        send_point(COORD_MAX, '0);
        send_point(-1, COORD_MIN);
        send_point(pick_coord(), pick_coord());
    endtask

    task automatic test_count_change_mid_curve();
        write_count(K_W'(6));
        send_random(4);
        write_count(K_W'(3));
        send_random(2);
        write_count(K_W'(5));
        send_random(3);
    endtask

    task automatic test_count_limit();
        write_count(K_W'(MAX_POINTS));
        send_random(MAX_POINTS);
        write_count(COUNT_TOP);
        send_random(MAX_POINTS + 1);
    endtask

    task automatic test_random_curves(input int budget);
        int sent;
        int k;
        int curves;
        int len;
        sent = 0;
        while (sent < budget) begin
            write_count(pick_count());
            k      = clamp_count(count_reg);
            curves = (k > 20) ? 1 : $urandom_range(1, 3);
            repeat (curves) begin
                len = k;
                if ($urandom_range(0, 7) == 0) len = $urandom_range(1, k);
                send_random(len);
                sent += len;
            end
        end
    endtask

    task automatic test_output_backpressure();
        write_count(K_W'(3));
        holds_asked++;
        send_random(12);
        drain(0);
    endtask

    task automatic test_no_idle();
        idle_on = 1'b0;
        write_count(K_W'($urandom_range(2, 6)));
        send_random(FINAL_ITEMS);
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        count_reg   = K_W'(4);
        last_x      = '0;
        last_y      = '0;
        next_index  = 0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;
        idle_on = 1'b1;

        test_reset_count();
        test_extreme_pairs();
        test_single_point();
        test_zero_count();
        test_count_change_mid_curve();
        test_count_limit();
        test_output_backpressure();
        test_random_curves(RANDOM_ITEMS);
        test_output_backpressure();
        test_no_idle();

        drain(SETTLE_CYCLES);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // receiver: long hold on request, random bursts otherwise while idle_on is set
    always @(negedge i_clk) begin
        if (holds_done != holds_asked) begin
            holds_done  <= holds_asked;
            stall_left  <= LONG_HOLD;
            i_out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left  <= $urandom_range(0, 9);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result x=%h y=%h end=%b",
                             o_out_data.out_x, o_out_data.out_y, o_out_data.end_of_curve);
            end else begin
                head_result = pending_results.pop_front();
                if (o_out_data.out_x !== head_result.out_x ||
                    o_out_data.out_y !== head_result.out_y ||
                    o_out_data.end_of_curve !== head_result.end_of_curve) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected x=%h y=%h end=%b, got x=%h y=%h end=%b",
                                 head_result.out_x, head_result.out_y,
                                 head_result.end_of_curve, o_out_data.out_x,
                                 o_out_data.out_y, o_out_data.end_of_curve);
                end
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

endmodule
